// ===== rtl/core/owdm_pkg.sv =====
// ----------------------------------------------------------------------------
// Omni-wheel drive mixer package
// Shared widths, command codes, wheel geometry and the cosine ROM contents.
// ----------------------------------------------------------------------------
package owdm_pkg;

  // Fixed point: wheel factor is signed Q1.F, F = COS_FRAC_BITS
  localparam int COS_FRAC_BITS = 15;
  localparam int COS_MAG_W     = COS_FRAC_BITS + 1;  // magnitude reaches 2^F
  localparam int DEG_W         = 9;
  localparam int QDEG_W        = 7;                  // 0..90 within a quadrant
  localparam int DUTY_W        = 8;
  localparam int PROD_W        = COS_MAG_W + DUTY_W;

  localparam logic [DEG_W-1:0] FULL_TURN = DEG_W'(360);
  localparam logic [DEG_W-1:0] HALF_TURN = DEG_W'(180);
  localparam logic [DEG_W-1:0] DEG_90    = DEG_W'(90);
  localparam logic [DEG_W-1:0] DEG_270   = DEG_W'(270);

  // Wheel lanes, the fourth one unused on a three-wheel base
  localparam int NUM_WHEELS = 4;

  // Wheel mounting angles
  localparam logic [DEG_W-1:0] TRI_A_DEG  = DEG_W'(150);
  localparam logic [DEG_W-1:0] TRI_B_DEG  = DEG_W'(30);
  localparam logic [DEG_W-1:0] TRI_C_DEG  = DEG_W'(270);
  localparam logic [DEG_W-1:0] QUAD_A_DEG = DEG_W'(45);
  localparam logic [DEG_W-1:0] QUAD_B_DEG = DEG_W'(135);
  localparam logic [DEG_W-1:0] QUAD_C_DEG = DEG_W'(225);
  localparam logic [DEG_W-1:0] QUAD_D_DEG = DEG_W'(315);

  // Drive commands
  typedef enum logic [1:0] {
    OP_MOVE       = 2'd0,
    OP_SPIN_LEFT  = 2'd1,
    OP_SPIN_RIGHT = 2'd2,
    OP_STOP       = 2'd3
  } op_e;

  // Per-wheel lane setup
  typedef struct packed {
    logic [DEG_W-1:0] angle;    // mounting angle
    logic             negate;   // factor sign flipped (four-wheel base)
    logic             present;  // wheel exists on this base
  } wheel_cfg_t;

  // Cosine ROM: 128 slots, entries 0..90 hold |cos| in Q1.F
  localparam int COS_ENTRIES = 1 << QDEG_W;
  localparam int COS_TABLE_W = COS_ENTRIES * COS_MAG_W;

  localparam longint unsigned Q30_ONE         = 64'd1073741824;
  localparam longint unsigned RAD_PER_DEG_Q30 = 64'd18740330;
  localparam int              SERIES_TERMS    = 11;

  // Series divisors (2n-1)(2n) as reciprocals: q = (v * R) >> 41 is exact for
  // v < 2^32 since every divisor is below 2^9; entry n-1 belongs to term n
  localparam int              SERIES_SHIFT = 41;
  localparam longint unsigned RECIP_ONE    = 64'd1 << SERIES_SHIFT;
  localparam logic [SERIES_TERMS-1:0][SERIES_SHIFT-1:0] SERIES_RECIP = {
    SERIES_SHIFT'((RECIP_ONE + 64'd461) / 64'd462),
    SERIES_SHIFT'((RECIP_ONE + 64'd379) / 64'd380),
    SERIES_SHIFT'((RECIP_ONE + 64'd305) / 64'd306),
    SERIES_SHIFT'((RECIP_ONE + 64'd239) / 64'd240),
    SERIES_SHIFT'((RECIP_ONE + 64'd181) / 64'd182),
    SERIES_SHIFT'((RECIP_ONE + 64'd131) / 64'd132),
    SERIES_SHIFT'((RECIP_ONE + 64'd89) / 64'd90),
    SERIES_SHIFT'((RECIP_ONE + 64'd55) / 64'd56),
    SERIES_SHIFT'((RECIP_ONE + 64'd29) / 64'd30),
    SERIES_SHIFT'((RECIP_ONE + 64'd11) / 64'd12),
    SERIES_SHIFT'((RECIP_ONE + 64'd1) / 64'd2)
  };

  // Elaboration-time only: Taylor series in Q2.30, clamped, then rounded to Q1.F
  function automatic logic [COS_TABLE_W-1:0] build_cos_table();
    logic [COS_TABLE_W-1:0] tbl;
    longint unsigned        x;
    longint unsigned        x2;
    longint unsigned        t;
    longint unsigned        c;
    longint unsigned        mag;
    longint unsigned        num;
    longint                 acc;
    int                     a;
    int                     n;
    tbl = '0;
    for (a = 0; a <= 90; a++) begin
      x   = longint'(a) * RAD_PER_DEG_Q30;
      x2  = (x * x) >> 30;
      t   = Q30_ONE;
      acc = longint'(Q30_ONE);
      for (n = 1; n <= SERIES_TERMS; n++) begin
        num = (t * x2) >> 30;   // stays below 2^32
        t   = 64'((80'(num) * 80'(SERIES_RECIP[n-1])) >> SERIES_SHIFT);
        if (n % 2 == 1) begin
          acc = acc - longint'(t);
        end else begin
          acc = acc + longint'(t);
        end
      end
      if (acc < 0) begin
        acc = 0;
      end
      if (acc > longint'(Q30_ONE)) begin
        acc = longint'(Q30_ONE);
      end
      c   = longint'(acc);
      mag = (c + (64'd1 << (29 - COS_FRAC_BITS))) >> (30 - COS_FRAC_BITS);
      tbl[a*COS_MAG_W +: COS_MAG_W] = mag[COS_MAG_W-1:0];
    end
    return tbl;
  endfunction

  localparam logic [COS_TABLE_W-1:0] COS_TABLE = build_cos_table();

endpackage

// ===== rtl/core/owdm_wheel.sv =====
// ----------------------------------------------------------------------------
// Omni-wheel drive mixer: wheel lane
// Turns one command into the forward and reverse duty of one wheel.
// ----------------------------------------------------------------------------
module owdm_wheel (
  input  owdm_pkg::wheel_cfg_t              cfg_i,
  input  owdm_pkg::op_e                     op_i,
  input  logic [owdm_pkg::DEG_W-1:0]        heading_i,  // already reduced to 0..359
  input  logic [owdm_pkg::DUTY_W-1:0]       speed_i,
  output logic [owdm_pkg::DUTY_W-1:0]       fwd_o,
  output logic [owdm_pkg::DUTY_W-1:0]       rev_o
);

  logic [owdm_pkg::DEG_W-1:0]     diff;
  logic [owdm_pkg::DEG_W-1:0]     fold;
  logic                           quad_neg;
  logic                           neg;
  logic [owdm_pkg::QDEG_W-1:0]    qdeg;
  logic [owdm_pkg::COS_MAG_W-1:0] mag;
  logic [owdm_pkg::PROD_W-1:0]    prod;
  logic [owdm_pkg::DUTY_W-1:0]    duty;

  // Angle between wheel and heading, 0..359
  always_comb begin
    if (cfg_i.angle >= heading_i) begin
      diff = cfg_i.angle - heading_i;
    end else begin
      diff = cfg_i.angle + owdm_pkg::FULL_TURN - heading_i;
    end
  end

  // Fold into the first quadrant, keep the sign
  always_comb begin
    priority if (diff <= owdm_pkg::DEG_90) begin
      fold     = diff;
      quad_neg = 1'b0;
    end else if (diff <= owdm_pkg::HALF_TURN) begin
      fold     = owdm_pkg::HALF_TURN - diff;
      quad_neg = 1'b1;
    end else if (diff <= owdm_pkg::DEG_270) begin
      fold     = diff - owdm_pkg::HALF_TURN;
      quad_neg = 1'b1;
    end else begin
      fold     = owdm_pkg::FULL_TURN - diff;
      quad_neg = 1'b0;
    end
  end

  assign qdeg = fold[owdm_pkg::QDEG_W-1:0];
  assign neg  = quad_neg ^ cfg_i.negate;

  // Cosine ROM and duty scaling
  assign mag  = owdm_pkg::COS_TABLE[qdeg*owdm_pkg::COS_MAG_W +: owdm_pkg::COS_MAG_W];
  assign prod = mag * speed_i;
  assign duty = prod[owdm_pkg::COS_FRAC_BITS +: owdm_pkg::DUTY_W];

  // Channel select per command; a zero duty leaves both channels at 0
  always_comb begin
    fwd_o = '0;
    rev_o = '0;
    if (cfg_i.present) begin
      unique case (op_i)
        owdm_pkg::OP_MOVE: begin
          if (neg) begin
            rev_o = duty;
          end else begin
            fwd_o = duty;
          end
        end
        owdm_pkg::OP_SPIN_LEFT:  fwd_o = speed_i;
        owdm_pkg::OP_SPIN_RIGHT: rev_o = speed_i;
        owdm_pkg::OP_STOP: begin
          fwd_o = '0;
          rev_o = '0;
        end
        default: begin
          fwd_o = '0;
          rev_o = '0;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/omni_wheel_drive_mixer.sv =====
// ----------------------------------------------------------------------------
// Omni-wheel drive mixer
// Maps move / spin / stop commands to per-wheel forward and reverse PWM duties.
// ----------------------------------------------------------------------------
// One command item is accepted per cycle unless out_ready_i back-pressure
// holds the pipeline; an item passes the input register, then the result
// register. Between the two registers four wheel lanes work in parallel,
// each a cosine ROM read and one 16x8 multiply, which sets the critical
// path. wheel_mode selects a three-wheel base (150/30/270 deg, wheel d held
// at zero) or a four-wheel base (45/135/225/315 deg, factor negated); it is
// sampled with each item and should only be written while no item is in
// flight. Headings of 360..511 wrap modulo 360.
module omni_wheel_drive_mixer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          wheel_mode_we_i,
  input  logic                          wheel_mode_i,
  // command channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    op_i,
  input  logic [owdm_pkg::DEG_W-1:0]    heading_deg_i,
  input  logic [owdm_pkg::DUTY_W-1:0]   speed_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [owdm_pkg::DUTY_W-1:0]   wheel_a_fwd_o,
  output logic [owdm_pkg::DUTY_W-1:0]   wheel_a_rev_o,
  output logic [owdm_pkg::DUTY_W-1:0]   wheel_b_fwd_o,
  output logic [owdm_pkg::DUTY_W-1:0]   wheel_b_rev_o,
  output logic [owdm_pkg::DUTY_W-1:0]   wheel_c_fwd_o,
  output logic [owdm_pkg::DUTY_W-1:0]   wheel_c_rev_o,
  output logic [owdm_pkg::DUTY_W-1:0]   wheel_d_fwd_o,
  output logic [owdm_pkg::DUTY_W-1:0]   wheel_d_rev_o
);

  logic                          wheel_mode_q;
  logic                          s1_valid_q;
  logic                          s1_valid_d;
  owdm_pkg::op_e                 s1_op_q;
  logic [owdm_pkg::DEG_W-1:0]    s1_heading_q;
  logic [owdm_pkg::DUTY_W-1:0]   s1_speed_q;
  logic                          s1_mode_q;
  logic                          out_valid_q;
  logic                          out_valid_d;
  logic                          s2_ready;
  logic                          in_accept;
  logic                          s1_advance;
  logic [owdm_pkg::DEG_W-1:0]    heading_red;
  owdm_pkg::wheel_cfg_t          wheel_cfg [owdm_pkg::NUM_WHEELS];
  logic [owdm_pkg::DUTY_W-1:0]   lane_fwd  [owdm_pkg::NUM_WHEELS];
  logic [owdm_pkg::DUTY_W-1:0]   lane_rev  [owdm_pkg::NUM_WHEELS];
  logic [owdm_pkg::DUTY_W-1:0]   fwd_q     [owdm_pkg::NUM_WHEELS];
  logic [owdm_pkg::DUTY_W-1:0]   rev_q     [owdm_pkg::NUM_WHEELS];

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wheel_mode_q <= 1'b0;
    end else if (wheel_mode_we_i) begin
      wheel_mode_q <= wheel_mode_i;
    end
  end

  // Handshake: each stage moves when the next one is free or draining
  assign s2_ready    = !out_valid_q || out_ready_i;
  assign in_ready_o  = !s1_valid_q || s2_ready;
  assign in_accept   = in_valid_i && in_ready_o;
  assign s1_advance  = s1_valid_q && s2_ready;
  assign s1_valid_d  = in_accept || (s1_valid_q && !s2_ready);
  assign out_valid_d = s1_advance || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Input register
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_op_q      <= owdm_pkg::op_e'(op_i);
      s1_heading_q <= heading_deg_i;
      s1_speed_q   <= speed_i;
      s1_mode_q    <= wheel_mode_q;
    end
  end

  // Heading wrap, one compare and subtract
  assign heading_red = (s1_heading_q >= owdm_pkg::FULL_TURN) ?
                       (s1_heading_q - owdm_pkg::FULL_TURN) : s1_heading_q;

  // Lane geometry per base
  always_comb begin
    if (s1_mode_q) begin
      wheel_cfg[0] = '{angle: owdm_pkg::QUAD_A_DEG, negate: 1'b1, present: 1'b1};
      wheel_cfg[1] = '{angle: owdm_pkg::QUAD_B_DEG, negate: 1'b1, present: 1'b1};
      wheel_cfg[2] = '{angle: owdm_pkg::QUAD_C_DEG, negate: 1'b1, present: 1'b1};
      wheel_cfg[3] = '{angle: owdm_pkg::QUAD_D_DEG, negate: 1'b1, present: 1'b1};
    end else begin
      wheel_cfg[0] = '{angle: owdm_pkg::TRI_A_DEG, negate: 1'b0, present: 1'b1};
      wheel_cfg[1] = '{angle: owdm_pkg::TRI_B_DEG, negate: 1'b0, present: 1'b1};
      wheel_cfg[2] = '{angle: owdm_pkg::TRI_C_DEG, negate: 1'b0, present: 1'b1};
      wheel_cfg[3] = '{angle: '0, negate: 1'b0, present: 1'b0};
    end
  end

  // Wheel lanes
  for (genvar w = 0; w < owdm_pkg::NUM_WHEELS; w++) begin : g_lane
    owdm_wheel u_wheel (
      .cfg_i     (wheel_cfg[w]),
      .op_i      (s1_op_q),
      .heading_i (heading_red),
      .speed_i   (s1_speed_q),
      .fwd_o     (lane_fwd[w]),
      .rev_o     (lane_rev[w])
    );
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (s1_advance) begin
      fwd_q <= lane_fwd;
      rev_q <= lane_rev;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign wheel_a_fwd_o = fwd_q[0];
  assign wheel_a_rev_o = rev_q[0];
  assign wheel_b_fwd_o = fwd_q[1];
  assign wheel_b_rev_o = rev_q[1];
  assign wheel_c_fwd_o = fwd_q[2];
  assign wheel_c_rev_o = rev_q[2];
  assign wheel_d_fwd_o = fwd_q[3];
  assign wheel_d_rev_o = rev_q[3];

  // An accepted item always reaches the input register
  a_accept_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> s1_valid_q)
    else $error("accepted item lost before input register");

  // An item leaving the input register always shows up at the output
  a_advance_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_advance |=> out_valid_o)
    else $error("item lost between input and result register");

  // A wheel never drives both directions at once
  a_one_direction: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((wheel_a_fwd_o == '0) || (wheel_a_rev_o == '0)) &&
                    ((wheel_b_fwd_o == '0) || (wheel_b_rev_o == '0)) &&
                    ((wheel_c_fwd_o == '0) || (wheel_c_rev_o == '0)) &&
                    ((wheel_d_fwd_o == '0) || (wheel_d_rev_o == '0)))
    else $error("wheel driven forward and reverse together");

endmodule
